// ===== rtl/srlp_pkg.sv =====
package srlp_pkg;

   localparam logic [7:0] CHAR_S    = 8'h53;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;
   localparam logic [7:0] CHAR_A    = 8'h41;
   localparam logic [7:0] CHAR_F    = 8'h46;

   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_START    = 3'd1;
   localparam logic [2:0] ERR_TYPE     = 3'd2;
   localparam logic [2:0] ERR_COUNT    = 3'd3;
   localparam logic [2:0] ERR_CHECKSUM = 3'd4;
   localparam logic [2:0] ERR_CHAR     = 3'd5;

   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   localparam logic [7:0] CHECKSUM_BASE = 8'hff;
   localparam int         MIN_COUNT     = 3;

   typedef struct packed {
      logic [7:0] char_in;
      logic       end_of_line;
   } req_type;

   typedef struct packed {
      logic        result_kind;
      logic [7:0]  data_byte;
      logic [7:0]  data_index;
      logic [31:0] line_address;
      logic [3:0]  record_type;
      logic [7:0]  byte_count;
      logic [2:0]  error_code;
   } rsp_type;

   typedef struct packed {
      logic       end_of_line;
      logic       is_start;
      logic       is_digit;
      logic       is_hex;
      logic [3:0] nibble;
   } entry_type;

endpackage

// ===== rtl/srlp_if.sv =====
interface srlp_req_if import srlp_pkg::*;;
   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface srlp_rsp_if import srlp_pkg::*;;
   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/srecord_line_parser_unit.sv =====
// S-record line parser.
// req_bus carries one transaction per line character (char_in, end_of_line
// low) and one end-of-line transaction per line (end_of_line high).
// rsp_bus returns decoded data bytes of S1/S2/S3 records (result_kind 0),
// issued one byte pair late so the checksum pair is never issued as data,
// and one status transaction per line (result_kind 1) with type, address,
// byte count and the first error found.
// A front stage classifies each character and writes it into a two-entry
// queue; a back stage updates the line state and owns the output register.
// An accepted transaction is written into the queue, and its result is then
// registered in the output register of the back stage. Throughput: one
// transaction per cycle while rsp_bus is ready.
// Characters past MAX_LINE_CHARS are dropped; the line is judged on the rest.
// When rsp_ready is low while the output register holds a valid transaction,
// it keeps that transaction, the back stage stops, and req_ready drops once the queue is full.
// Synchronous reset clears the queue, the line state and the output valid.
module srecord_line_parser_unit import srlp_pkg::*; #(
   parameter int MAX_LINE_CHARS = 1023
) (
   input  logic       clock,
   input  logic       reset,
   srlp_req_if.sink   req_bus,
   srlp_rsp_if.source rsp_bus
);

   entry_type front_entry;
   entry_type head_entry;
   logic      queue_full;
   logic      queue_not_empty;
   logic      queue_pop;

   assign req_bus.ready = !queue_full;

   srlp_front u_front (
      .req_payload (req_bus.payload),
      .entry       (front_entry)
   );

   srlp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_bus.valid),
      .push_entry (front_entry),
      .full       (queue_full),
      .pop        (queue_pop),
      .not_empty  (queue_not_empty),
      .head       (head_entry)
   );

   srlp_back #(
      .MAX_LINE_CHARS (MAX_LINE_CHARS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .entry_valid (queue_not_empty),
      .entry       (head_entry),
      .entry_pop   (queue_pop),
      .rsp_valid   (rsp_bus.valid),
      .rsp_payload (rsp_bus.payload),
      .rsp_ready   (rsp_bus.ready)
   );

endmodule

// ===== rtl/srlp_front.sv =====
module srlp_front import srlp_pkg::*; (
   input  req_type   req_payload,
   output entry_type entry
);

   logic [7:0] c;
   logic       digit;
   logic       letter;

   assign c      = req_payload.char_in;
   assign digit  = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   assign letter = (c >= CHAR_A) && (c <= CHAR_F);

   always_comb begin
      entry.end_of_line = req_payload.end_of_line;
      entry.is_start    = (c == CHAR_S);
      entry.is_digit    = digit;
      entry.is_hex      = digit || letter;
      if (digit) begin
         entry.nibble = c[3:0];
      end else if (letter) begin
         entry.nibble = 4'(c - CHAR_A) + 4'd10;
      end else begin
         entry.nibble = 4'd0;
      end
   end

endmodule

// ===== rtl/srlp_queue.sv =====
module srlp_queue import srlp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      not_empty,
   output entry_type head
);

   entry_type  slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push;
   logic       do_pop;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/srlp_back.sv =====
module srlp_back import srlp_pkg::*; #(
   parameter int MAX_LINE_CHARS = 1023
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      entry_valid,
   input  entry_type entry,
   output logic      entry_pop,
   output logic      rsp_valid,
   output rsp_type   rsp_payload,
   input  logic      rsp_ready
);

   localparam int PW = $clog2(MAX_LINE_CHARS + 1);
   localparam int CW = (PW > 8) ? PW : 8;
   localparam logic [PW-1:0] MAX_POS = PW'(MAX_LINE_CHARS);

   logic [PW-1:0] pos_ff, pos_in;
   logic [3:0]    high_ff, high_in;
   logic [7:0]    held_ff, held_in;
   logic          held_valid_ff, held_valid_in;
   logic [7:0]    sum_ff, sum_in;
   logic [3:0]    type_ff, type_in;
   logic [7:0]    count_ff, count_in;
   logic [31:0]   addr_ff, addr_in;
   logic [2:0]    err_ff, err_in;
   logic [7:0]    dcount_ff, dcount_in;
   logic          out_valid_ff, out_valid_in;
   rsp_type       out_ff, out_in;

   logic          take;
   logic          addressed;
   logic [PW-1:0] addr_end;
   logic [PW-1:0] data_start;
   logic [PW-1:0] half_len;
   logic [2:0]    final_err;
   logic [7:0]    byte_val;
   logic [3:0]    nib;
   logic          emit;

   assign entry_pop   = entry_valid && (!out_valid_ff || rsp_ready);
   assign take        = entry_pop;
   assign addressed   = (type_ff >= 4'd1) && (type_ff <= 4'd3);
   assign addr_end    = PW'({type_ff, 1'b0}) + PW'(6);
   assign data_start  = PW'({type_ff, 1'b0}) + PW'(8);
   assign half_len    = (pos_ff - PW'(4)) >> 1;
   assign nib         = entry.is_hex ? entry.nibble : 4'd0;
   assign byte_val    = {high_ff, nib};
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   always_comb begin
      final_err = err_ff;
      if (err_ff == ERR_NONE) begin
         if (pos_ff < PW'(4) || count_ff < 8'(MIN_COUNT) ||
             CW'(count_ff) > CW'(half_len)) begin
            final_err = ERR_COUNT;
         end else if (pos_ff[0]) begin
            final_err = ERR_CHECKSUM;
         end else if (CHECKSUM_BASE - sum_ff != held_ff) begin
            final_err = ERR_CHECKSUM;
         end
      end
   end

   always_comb begin
      pos_in        = pos_ff;
      high_in       = high_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      sum_in        = sum_ff;
      type_in       = type_ff;
      count_in      = count_ff;
      addr_in       = addr_ff;
      err_in        = err_ff;
      dcount_in     = dcount_ff;
      out_in        = out_ff;
      emit          = 1'b0;

      if (take && entry.end_of_line) begin
         out_in.result_kind  = KIND_STATUS;
         out_in.data_byte    = 8'd0;
         out_in.data_index   = 8'd0;
         out_in.line_address = addressed ? addr_ff : 32'd0;
         out_in.record_type  = type_ff;
         out_in.byte_count   = count_ff;
         out_in.error_code   = final_err;
         pos_in        = '0;
         high_in       = 4'd0;
         held_in       = 8'd0;
         held_valid_in = 1'b0;
         sum_in        = 8'd0;
         type_in       = 4'd0;
         count_in      = 8'd0;
         addr_in       = 32'd0;
         err_in        = ERR_NONE;
         dcount_in     = 8'd0;
      end else if (take && pos_ff < MAX_POS) begin
         pos_in = pos_ff + PW'(1);
         if (pos_ff == '0) begin
            if (!entry.is_start && err_ff == ERR_NONE) begin
               err_in = ERR_START;
            end
         end else if (pos_ff == PW'(1)) begin
            if (entry.is_digit) begin
               type_in = entry.nibble;
            end else if (err_ff == ERR_NONE) begin
               err_in = ERR_TYPE;
            end
         end else begin
            if (!entry.is_hex && err_ff == ERR_NONE) begin
               err_in = ERR_CHAR;
            end
            if (addressed && pos_ff >= PW'(4) && pos_ff < addr_end) begin
               addr_in = {addr_ff[27:0], nib};
            end
            if (!pos_ff[0]) begin
               high_in = nib;
            end else begin
               if (pos_ff == PW'(3)) begin
                  count_in = byte_val;
               end
               if (held_valid_ff) begin
                  sum_in = sum_ff + held_ff;
                  if (addressed && err_ff != ERR_START && err_ff != ERR_TYPE &&
                      (pos_ff - PW'(1)) >= data_start) begin
                     emit                = 1'b1;
                     out_in.result_kind  = KIND_DATA;
                     out_in.data_byte    = held_ff;
                     out_in.data_index   = dcount_ff;
                     out_in.line_address = 32'd0;
                     out_in.record_type  = 4'd0;
                     out_in.byte_count   = 8'd0;
                     out_in.error_code   = ERR_NONE;
                     dcount_in           = dcount_ff + 8'd1;
                  end
               end
               held_in       = byte_val;
               held_valid_in = 1'b1;
            end
         end
      end

      if (take && (entry.end_of_line || emit)) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         high_ff       <= 4'd0;
         held_ff       <= 8'd0;
         held_valid_ff <= 1'b0;
         sum_ff        <= 8'd0;
         type_ff       <= 4'd0;
         count_ff      <= 8'd0;
         addr_ff       <= 32'd0;
         err_ff        <= ERR_NONE;
         dcount_ff     <= 8'd0;
         out_valid_ff  <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         high_ff       <= high_in;
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
         sum_ff        <= sum_in;
         type_ff       <= type_in;
         count_ff      <= count_in;
         addr_ff       <= addr_in;
         err_ff        <= err_in;
         dcount_ff     <= dcount_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

endmodule

// ===== rtl/srlp_checker.sv =====
module srlp_checker import srlp_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);

   a_rsp_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   a_rsp_payload_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_payload))
      else $error("rsp payload changed while stalled");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   a_data_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.result_kind == KIND_DATA |->
         rsp_payload.error_code == ERR_NONE && rsp_payload.record_type == 4'd0 &&
         rsp_payload.line_address == 32'd0 && rsp_payload.byte_count == 8'd0)
      else $error("data transaction carries status fields");

   a_status_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.result_kind == KIND_STATUS |->
         rsp_payload.error_code <= ERR_CHAR && rsp_payload.record_type <= 4'd9 &&
         rsp_payload.data_byte == 8'd0 && rsp_payload.data_index == 8'd0)
      else $error("status transaction out of range");

endmodule

bind srecord_line_parser_unit srlp_checker u_srlp_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .rsp_payload (rsp_bus.payload)
);

// ===== test/srlp_line_checker.sv =====
`timescale 1ns / 100ps

module srlp_line_checker import srlp_pkg::*; #(
   parameter int MAX_LINE_CHARS = 1023
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_payload,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_payload,
   output int      mismatch_count,
   output int      pending_count
);

   localparam int POS_BITS     = $clog2(MAX_LINE_CHARS + 1);
   localparam int REPORT_LIMIT = 10;

   logic [POS_BITS-1:0] char_pos;
   logic [3:0]          hi_nibble;
   logic [7:0]          held_pair;
   logic                held_ok;
   logic [7:0]          pair_sum;
   logic [3:0]          rec_digit;
   logic [7:0]          count_field;
   logic [31:0]         load_addr;
   logic [2:0]          first_fault;
   logic [7:0]          data_seq;

   rsp_type awaited_records [$];
   int      fails = 0;

   task automatic clear_line();
      char_pos    = '0;
      hi_nibble   = '0;
      held_pair   = '0;
      held_ok     = 1'b0;
      pair_sum    = '0;
      rec_digit   = '0;
      count_field = '0;
      load_addr   = '0;
      first_fault = ERR_NONE;
      data_seq    = '0;
   endtask

   task automatic note_fault(input logic [2:0] code);
      if (first_fault == ERR_NONE) begin
         first_fault = code;
      end
   endtask

   function automatic logic has_address();
      return rec_digit >= 4'd1 && rec_digit <= 4'd3;
   endfunction

   function automatic string describe(input rsp_type r);
      return $sformatf("kind %0d byte %h index %0d addr %h type %0d count %h err %0d",
                       r.result_kind, r.data_byte, r.data_index, r.line_address,
                       r.record_type, r.byte_count, r.error_code);
   endfunction

   task automatic parse_transaction(input req_type t);
      rsp_type    r;
      logic [2:0] fault;
      logic [7:0] c;
      logic [7:0] pair;
      logic [7:0] check;
      logic [3:0] nib;
      int         p;
      int         addr_chars;
      r = '0;
      addr_chars = int'(rec_digit) * 2 + 2;
      if (t.end_of_line) begin
         fault = first_fault;
         check = CHECKSUM_BASE - pair_sum;
         if (fault == ERR_NONE) begin
            if (char_pos < 4 || count_field < MIN_COUNT ||
                int'(count_field) > (int'(char_pos) - 4) / 2) begin
               fault = ERR_COUNT;
            end else if (char_pos[0] || check != held_pair) begin
               fault = ERR_CHECKSUM;
            end
         end
         r.result_kind  = KIND_STATUS;
         r.line_address = has_address() ? load_addr : 32'h0;
         r.record_type  = rec_digit;
         r.byte_count   = count_field;
         r.error_code   = fault;
         awaited_records.push_back(r);
         clear_line();
      end else if (int'(char_pos) < MAX_LINE_CHARS) begin
         p = int'(char_pos);
         c = t.char_in;
         char_pos = char_pos + 1'b1;
         if (p == 0) begin
            if (c != CHAR_S) note_fault(ERR_START);
         end else if (p == 1) begin
            if (c >= CHAR_ZERO && c <= CHAR_NINE) rec_digit = 4'(c - CHAR_ZERO);
            else note_fault(ERR_TYPE);
         end else begin
            if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
               nib = 4'(c - CHAR_ZERO);
            end else if (c >= CHAR_A && c <= CHAR_F) begin
               nib = 4'(c - CHAR_A + 10);
            end else begin
               nib = 4'h0;
               note_fault(ERR_CHAR);
            end
            if (has_address() && p >= 4 && p < 4 + addr_chars) begin
               load_addr = {load_addr[27:0], nib};
            end
            if (p % 2 == 0) begin
               hi_nibble = nib;
            end else begin
               pair = {hi_nibble, nib};
               if (p == 3) count_field = pair;
               if (held_ok) begin
                  pair_sum = pair_sum + held_pair;
                  if (has_address() && first_fault != ERR_START &&
                      first_fault != ERR_TYPE && p - 1 >= 6 + addr_chars) begin
                     r.result_kind = KIND_DATA;
                     r.data_byte   = held_pair;
                     r.data_index  = data_seq;
                     data_seq      = data_seq + 1'b1;
                     awaited_records.push_back(r);
                  end
               end
               held_pair = pair;
               held_ok   = 1'b1;
            end
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         clear_line();
         awaited_records.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_records.size() == 0) begin
               fails++;
               if (fails <= REPORT_LIMIT) begin
                  $display("%0t: unexpected result: %s", $realtime, describe(rsp_payload));
               end
            end else begin
               want = awaited_records.pop_front();
               if (rsp_payload.result_kind !== want.result_kind ||
                   rsp_payload.data_byte !== want.data_byte ||
                   rsp_payload.data_index !== want.data_index ||
                   rsp_payload.line_address !== want.line_address ||
                   rsp_payload.record_type !== want.record_type ||
                   rsp_payload.byte_count !== want.byte_count ||
                   rsp_payload.error_code !== want.error_code) begin
                  fails++;
                  if (fails <= REPORT_LIMIT) begin
                     $display("%0t: mismatch: expected %s", $realtime, describe(want));
                     $display("%0t:           actual   %s", $realtime,
                              describe(rsp_payload));
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            parse_transaction(req_payload);
         end
      end
      mismatch_count <= fails;
      pending_count  <= awaited_records.size();
   end

endmodule

// ===== test/tb_srecord_line_parser_unit.sv =====
`timescale 1ns / 100ps

module tb_srecord_line_parser_unit;
   import srlp_pkg::*;

   localparam int         LINE_LIMIT   = 1023;
   localparam int         RANDOM_CHARS = 150;
   localparam int         DRAIN_CYCLES = 16;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_NUL     = 8'h00;

   typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_type;
   typedef enum {STALL_NONE, STALL_HALF, STALL_HEAVY, STALL_CYCLIC} stall_type;
   typedef enum {
      FLAW_CHECKSUM, FLAW_CASE, FLAW_CHAR, FLAW_START, FLAW_TYPE, FLAW_ODD,
      FLAW_SHORT, FLAW_COUNT_LOW, FLAW_COUNT_HIGH, FLAW_EXTRA, FLAW_NOISE
   } flaw_type;

   logic      clock = 1'b0;
   logic      reset;
   int        mismatch_count;
   int        pending_count;
   int        burst_left = 0;
   int        chars_sent = 0;
   int        stall_left = 0;
   stall_type stall_mode = STALL_NONE;
   logic [7:0] text [$];

   srlp_req_if req_bus ();
   srlp_rsp_if rsp_bus ();

   srecord_line_parser_unit #(.MAX_LINE_CHARS(LINE_LIMIT)) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   srlp_line_checker #(.MAX_LINE_CHARS(LINE_LIMIT)) line_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_bus.valid),
      .req_ready      (req_bus.ready),
      .req_payload    (req_bus.payload),
      .rsp_valid      (rsp_bus.valid),
      .rsp_ready      (rsp_bus.ready),
      .rsp_payload    (rsp_bus.payload),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= stall_type'($urandom_range(0, 3));
         stall_left <= $urandom_range(20, 200);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         STALL_NONE:  rsp_bus.ready <= 1'b1;
         STALL_HALF:  rsp_bus.ready <= 1'($urandom_range(0, 1));
         STALL_HEAVY: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
         default:     rsp_bus.ready <= (stall_left % 7) > 1;
      endcase
   end

   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      return (nib < 10) ? CHAR_ZERO + 8'(nib) : CHAR_A + 8'(nib - 10);
   endfunction

   function automatic logic [7:0] fill_byte(input fill_type f);
      case (f)
         FILL_ZERO: return 8'h00;
         FILL_ONES: return 8'hff;
         default:   return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_item(input logic [7:0] ch, input logic eol);
      if (burst_left == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
      req_bus.valid   <= 1'b1;
      req_bus.payload <= '{char_in: ch, end_of_line: eol};
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      burst_left = burst_left - 1;
      if (!eol) chars_sent = chars_sent + 1;
   endtask

   task automatic send_line();
      foreach (text[i]) send_item(text[i], 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic build_record(input int rtype, input int ndata, input fill_type f);
      logic [7:0] body [$];
      logic [7:0] sum;
      int         abytes;
      case (rtype)
         2, 6, 8: abytes = 3;
         3, 7:    abytes = 4;
         default: abytes = 2;
      endcase
      body.push_back(8'(abytes + ndata + 1));
      repeat (abytes + ndata) body.push_back(fill_byte(f));
      sum = '0;
      foreach (body[i]) sum = sum + body[i];
      body.push_back(CHECKSUM_BASE - sum);
      text = {};
      text.push_back(CHAR_S);
      text.push_back(CHAR_ZERO + 8'(rtype));
      foreach (body[i]) begin
         text.push_back(hex_digit(body[i][7:4]));
         text.push_back(hex_digit(body[i][3:0]));
      end
   endtask

   task automatic apply_flaw(input flaw_type f);
      int spot;
      spot = (text.size() > 2) ? $urandom_range(2, text.size() - 1) : 0;
      case (f)
         FLAW_CHECKSUM: begin
            text[text.size() - 1] = (text[text.size() - 1] == CHAR_ZERO) ? CHAR_A : CHAR_ZERO;
         end
         FLAW_CASE:       text[spot] = CHAR_LOWER_A + 8'($urandom_range(0, 5));
         FLAW_CHAR:       text[spot] = 8'($urandom_range(0, 255));
         FLAW_START:      text[0] = 8'($urandom_range(0, 255));
         FLAW_TYPE:       text[1] = 8'($urandom_range(0, 255));
         FLAW_ODD:        void'(text.pop_back());
         FLAW_SHORT: begin
            spot = $urandom_range(0, 5);
            while (text.size() > spot) void'(text.pop_back());
         end
         FLAW_COUNT_LOW: begin
            text[2] = CHAR_ZERO;
            text[3] = CHAR_ZERO + 8'($urandom_range(0, 2));
         end
         FLAW_COUNT_HIGH: begin
            void'(text.pop_back());
            void'(text.pop_back());
         end
         FLAW_EXTRA: begin
            text.push_back(hex_digit(4'($urandom_range(0, 15))));
            text.push_back(hex_digit(4'($urandom_range(0, 15))));
         end
         default: begin
            text = {};
            repeat ($urandom_range(0, 40)) text.push_back(8'($urandom_range(0, 255)));
            if (text.size() > 0 && $urandom_range(0, 1) == 1) text[0] = CHAR_S;
         end
      endcase
   endtask

   initial begin
      int goal;
      int rtype;
      int ndata;
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.payload = '0;
      rsp_bus.ready   = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      build_record(1, 0, FILL_ZERO);
      send_line();
      build_record(1, 2, FILL_ONES);
      send_line();
      build_record(2, 3, FILL_ZERO);
      send_line();
      build_record(2, 1, FILL_ONES);
      send_line();
      build_record(3, 4, FILL_ONES);
      send_line();
      build_record(3, 0, FILL_ZERO);
      send_line();
      for (int k = 0; k < 10; k++) begin
         build_record(k, k % 3, FILL_RANDOM);
         send_line();
      end
      text = {};
      send_line();
      text = {CHAR_S};
      send_line();
      text = {CHAR_S, CHAR_ZERO + 8'd1};
      send_line();
      text = {CHAR_S, CHAR_ZERO + 8'd1, CHAR_F};
      send_line();
      build_record(2, 3, FILL_RANDOM);
      text[7] = CHAR_NUL;
      send_line();
      for (int f = FLAW_CHECKSUM; f <= FLAW_NOISE; f++) begin
         build_record(1, 4, FILL_RANDOM);
         apply_flaw(flaw_type'(f));
         send_line();
      end
      build_record(3, 250, FILL_ONES);
      while (text.size() < LINE_LIMIT + 8) text.push_back(hex_digit(4'($urandom_range(0, 15))));
      send_line();

      goal = chars_sent + RANDOM_CHARS;
      while (chars_sent < goal) begin
         rtype = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 3) : $urandom_range(0, 9);
         ndata = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 250) : $urandom_range(0, 24);
         build_record(rtype, ndata, FILL_RANDOM);
         if ($urandom_range(0, 9) < 3) apply_flaw(flaw_type'($urandom_range(0, FLAW_NOISE)));
         send_line();
      end

      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
